FILE: rtl/e2r_pkg.sv
// Package for the Euler-angle to rotation-matrix block.
// Holds widths, CORDIC constants and the types shared by the cell and the top level.
package e2r_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int COEF_BITS = 16;
	localparam int STEPS = 16;
	localparam int FRAC = 30;
	localparam int OUT_F = COEF_BITS - 2;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;
	localparam logic [63:0] TURN_SCALE = 64'd683565276;

	// CORDIC working values: x and y in Q1.30 (grow a little), residual angle
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
	} cordic_t;

	typedef struct packed {
		cordic_t cx;
		cordic_t cy;
		cordic_t cz;
		logic [1:0] kx;
		logic [1:0] ky;
		logic [1:0] kz;
	} lane_t;

	function automatic logic signed [31:0] atan_turn(input logic [3:0] i);
		logic signed [31:0] r;
		begin
			unique case (i)
				4'd0: r = 32'sh20000000;
				4'd1: r = 32'sh12E4051E;
				4'd2: r = 32'sh09FB385B;
				4'd3: r = 32'sh051111D4;
				4'd4: r = 32'sh028B0D43;
				4'd5: r = 32'sh0145D7E1;
				4'd6: r = 32'sh00A2F61E;
				4'd7: r = 32'sh00517C55;
				4'd8: r = 32'sh0028BE53;
				4'd9: r = 32'sh00145F2F;
				4'd10: r = 32'sh000A2F98;
				4'd11: r = 32'sh000517CC;
				4'd12: r = 32'sh00028BE6;
				4'd13: r = 32'sh000145F3;
				4'd14: r = 32'sh0000A2FA;
				default: r = 32'sh0000517D;
			endcase
			return r;
		end
	endfunction
endpackage

FILE: rtl/e2r_cell.sv
// One CORDIC rotation cell: advances the three angles of one item by one step.
// Depends on e2r_pkg.
module e2r_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [3:0]           step,
	input  logic                 en,
	input  logic                 vld_in,
	input  e2r_pkg::lane_t       lane_in,
	output logic                 vld_q,
	output e2r_pkg::lane_t       lane_q
);
	import e2r_pkg::*;

	function automatic cordic_t rot(input cordic_t c, input logic [3:0] i);
		cordic_t r;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		begin
			xs = c.x >>> i;
			ys = c.y >>> i;
			if (!c.z[31]) begin
				r.x = c.x - ys;
				r.y = c.y + xs;
				r.z = c.z - atan_turn(i);
			end else begin
				r.x = c.x + ys;
				r.y = c.y - xs;
				r.z = c.z + atan_turn(i);
			end
			return r;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.cx <= rot(lane_in.cx, step);
			lane_q.cy <= rot(lane_in.cy, step);
			lane_q.cz <= rot(lane_in.cz, step);
			lane_q.kx <= lane_in.kx;
			lane_q.ky <= lane_in.ky;
			lane_q.kz <= lane_in.kz;
		end
	end
endmodule

FILE: rtl/euler_to_rotation_matrix_top.sv
// Top level: phase mapping, chain of 16 CORDIC cells, product stages, output.
// Depends on e2r_pkg and e2r_cell.
//
// channel | dir | fields
// s_axis  | in  | tdata = angle_x, angle_y, angle_z (16 b each)
// m_axis  | out | tdata = m00..m22 (16 b each, row-major)
//
// One item per cycle unless m_axis stalls; phase, 16 cells, then 4 output stages.
// The whole pipeline advances whenever the output register is free or being taken.
// A stall on m_axis holds every stage; arst_n clears all valid flags.
module euler_to_rotation_matrix_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // angle_x, angle_y, angle_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata   // m00 m01 m02 m10 m11 m12 m20 m21 m22
);
	import e2r_pkg::*;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	function automatic cordic_t phase(input logic signed [15:0] a, output logic [1:0] k);
		logic signed [63:0] prod;
		logic [31:0] p;
		logic [31:0] r;
		cordic_t c;
		begin
			prod = 64'(a) * $signed(TURN_SCALE);
			p = prod[ANGLE_BITS-3 +: 32];
			k = 2'(32'(p + 32'h20000000) >> 30);
			r = p - {k, 30'd0};
			c.x = 34'(CORDIC_GAIN);
			c.y = '0;
			c.z = $signed(r);
			return c;
		end
	endfunction

	// stage 0: phase
	logic   v0_q;
	lane_t  l0_q;
	logic [1:0] k0x, k0y, k0z;
	cordic_t c0x, c0y, c0z;
	always_comb begin
		c0x = phase(s_axis_tdata[15:0], k0x);
		c0y = phase(s_axis_tdata[31:16], k0y);
		c0z = phase(s_axis_tdata[47:32], k0z);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v0_q <= 1'b0;
		else if (en) v0_q <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			l0_q <= '{cx: c0x, cy: c0y, cz: c0z, kx: k0x, ky: k0y, kz: k0z};
		end
	end

	logic  vc [STEPS+1];
	lane_t lc [STEPS+1];
	assign vc[0] = v0_q;
	assign lc[0] = l0_q;
	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		e2r_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step(4'(g)), .en(en),
			.vld_in(vc[g]), .lane_in(lc[g]), .vld_q(vc[g+1]), .lane_q(lc[g+1])
		);
	end

	function automatic logic signed [33:0] qsel_c(input cordic_t c, input logic [1:0] k);
		unique case (k)
			2'd0: return c.x;
			2'd1: return -c.y;
			2'd2: return -c.x;
			default: return c.y;
		endcase
	endfunction
	function automatic logic signed [33:0] qsel_s(input cordic_t c, input logic [1:0] k);
		unique case (k)
			2'd0: return c.y;
			2'd1: return c.x;
			2'd2: return -c.y;
			default: return -c.x;
		endcase
	endfunction
	function automatic logic signed [33:0] mul(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		begin
			p = a * b + 68'sd536870912;
			return 34'(p >>> FRAC);
		end
	endfunction

	// stage s1: quadrant fix
	logic v_s1;
	logic signed [33:0] cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	// stage s2: two-factor terms
	logic v_s2;
	logic signed [33:0] sysx_s2, sycx_s2, cysx_s2, cycx_s2, czcy_s2, szcy_s2;
	logic signed [33:0] szcx_s2, szsx_s2, czcx_s2, czsx_s2, sy_s2, cz_s2, sz_s2;
	// stage s3: three-factor terms
	logic v_s3;
	logic signed [34:0] e_s3 [9];
	// stage s4: rounded output
	logic v_s4;
	logic [143:0] d_s4;

	function automatic logic [15:0] to_out(input logic signed [34:0] v);
		logic signed [35:0] r;
		localparam int D = FRAC - OUT_F;
		localparam logic signed [35:0] LIM = 36'sd1 <<< OUT_F;
		begin
			r = (36'(v) + (36'sd1 <<< (D - 1))) >>> D;
			if (r > LIM) r = LIM;
			if (r < -LIM) r = -LIM;
			return r[15:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vc[STEPS]; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= qsel_c(lc[STEPS].cx, lc[STEPS].kx);
			sx_s1 <= qsel_s(lc[STEPS].cx, lc[STEPS].kx);
			cy_s1 <= qsel_c(lc[STEPS].cy, lc[STEPS].ky);
			sy_s1 <= qsel_s(lc[STEPS].cy, lc[STEPS].ky);
			cz_s1 <= qsel_c(lc[STEPS].cz, lc[STEPS].kz);
			sz_s1 <= qsel_s(lc[STEPS].cz, lc[STEPS].kz);

			sysx_s2 <= mul(sy_s1, sx_s1);
			sycx_s2 <= mul(sy_s1, cx_s1);
			cysx_s2 <= mul(cy_s1, sx_s1);
			cycx_s2 <= mul(cy_s1, cx_s1);
			czcy_s2 <= mul(cz_s1, cy_s1);
			szcy_s2 <= mul(sz_s1, cy_s1);
			szcx_s2 <= mul(sz_s1, cx_s1);
			szsx_s2 <= mul(sz_s1, sx_s1);
			czcx_s2 <= mul(cz_s1, cx_s1);
			czsx_s2 <= mul(cz_s1, sx_s1);
			sy_s2 <= sy_s1; cz_s2 <= cz_s1; sz_s2 <= sz_s1;

			e_s3[0] <= 35'(czcy_s2);
			e_s3[1] <= 35'(mul(cz_s2, sysx_s2)) + 35'(szcx_s2);
			e_s3[2] <= 35'(szsx_s2) - 35'(mul(cz_s2, sycx_s2));
			e_s3[3] <= -35'(szcy_s2);
			e_s3[4] <= 35'(czcx_s2) - 35'(mul(sz_s2, sysx_s2));
			e_s3[5] <= 35'(mul(sz_s2, sycx_s2)) + 35'(czsx_s2);
			e_s3[6] <= 35'(sy_s2);
			e_s3[7] <= -35'(cysx_s2);
			e_s3[8] <= 35'(cycx_s2);

			for (int i = 0; i < 9; i++) d_s4[16*i +: 16] <= to_out(e_s3[i]);
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = d_s4;
endmodule

FILE: rtl/e2r_checker.sv
// Port-level checker for the Euler-angle to rotation-matrix block, with its bind.
// Depends on euler_to_rotation_matrix_top ports only.
module e2r_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output space");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384
			&& $signed(m_axis_tdata[15:0]) >= -16'sd16384)
		else $error("m00 out of range");
endmodule

bind euler_to_rotation_matrix_top e2r_checker u_e2r_checker (.*);

FILE: bench/tb_euler_to_rotation_matrix_top.sv
// Self-checking bench for euler_to_rotation_matrix_top: random and corner angle triples,
// predicted matrices compared entry by entry. Depends on e2r_pkg and the RTL top level.
module tb_euler_to_rotation_matrix_top;
	timeunit 1ns;
	timeprecision 1ps;
	import e2r_pkg::*;

	typedef struct packed {
		logic signed [15:0] az;
		logic signed [15:0] ay;
		logic signed [15:0] ax;
	} angles_t;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 60;
	localparam int N_RANDOM = 830;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;

	angles_t pending_angles[$];
	logic [143:0] expected_matrices[$];
	int n_mismatch = 0;
	int n_checked = 0;
	int n_sent = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_sink = 1'b0;
	bit pause_src = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;

	always #4 clk = ~clk;

	euler_to_rotation_matrix_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return floor_shr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	// CORDIC sine/cosine of a Q3.13 angle, both Q1.30
	task automatic sincos(input logic signed [15:0] ang, output longint co, output longint si);
		longint prod, x, y, z, xs, ys;
		logic [31:0] p, r;
		logic [1:0] k;
		begin
			prod = longint'(ang) * longint'(TURN_SCALE);
			p = prod[44:13];
			k = 2'((p + 32'h2000_0000) >> 30);
			r = p - {k, 30'd0};
			z = longint'($signed(r));
			x = longint'(CORDIC_GAIN);
			y = 0;
			for (int i = 0; i < STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= longint'(atan_turn(4'(i)));
				end else begin
					x += ys; y -= xs; z += longint'(atan_turn(4'(i)));
				end
			end
			case (k)
				2'd0: begin co = x; si = y; end
				2'd1: begin co = -y; si = x; end
				2'd2: begin co = -x; si = -y; end
				default: begin co = y; si = -x; end
			endcase
		end
	endtask

	function automatic logic [15:0] round_coef(longint v);
		longint lim;
		lim = 64'sd1 <<< OUT_F;
		v = floor_shr(v + (64'sd1 <<< (FRAC - OUT_F - 1)), FRAC - OUT_F);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[15:0];
	endfunction

	task automatic predict_matrix(input angles_t a, output logic [143:0] m);
		longint cx, sx, cy, sy, cz, sz, sysx, sycx, cysx, cycx;
		begin
			sincos(a.ax, cx, sx);
			sincos(a.ay, cy, sy);
			sincos(a.az, cz, sz);
			sysx = qmul(sy, sx);
			sycx = qmul(sy, cx);
			cysx = qmul(cy, sx);
			cycx = qmul(cy, cx);
			m[15:0] = round_coef(qmul(cz, cy));
			m[31:16] = round_coef(qmul(cz, sysx) + qmul(sz, cx));
			m[47:32] = round_coef(qmul(sz, sx) - qmul(cz, sycx));
			m[63:48] = round_coef(-qmul(sz, cy));
			m[79:64] = round_coef(qmul(cz, cx) - qmul(sz, sysx));
			m[95:80] = round_coef(qmul(sz, sycx) + qmul(cz, sx));
			m[111:96] = round_coef(sy);
			m[127:112] = round_coef(-cysx);
			m[143:128] = round_coef(cycx);
		end
	endtask

	// mostly angles within plus or minus pi, some anywhere (phase wraps)
	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 64)) - 32);
			2: return ($urandom_range(0, 1)) ? 16'sd25736 : -16'sd25736;
			default: return 16'($signed($urandom_range(0, 51472)) - 25736);
		endcase
	endfunction

	// sender
	always @(posedge clk) begin
		logic [143:0] m;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_matrix(angles_t'(s_axis_tdata), m);
				expected_matrices.push_back(m);
				n_sent <= n_sent + 1;
			end
			if (src_gap > 0) src_gap <= src_gap - 1;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pause_src || pending_angles.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (!calm && src_gap == 0 && $urandom_range(0, 15) == 0) begin
					s_axis_tvalid <= 1'b0;
					src_gap <= $urandom_range(1, 17);
				end else if (src_gap == 0 || calm) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_angles.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		logic [143:0] exp_m;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_matrices.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected matrix transfer %h", m_axis_tdata);
				end else begin
					exp_m = expected_matrices.pop_front();
					n_checked++;
					for (int e = 0; e < 9; e++) begin
						if (m_axis_tdata[e*16 +: 16] !== exp_m[e*16 +: 16]) begin
							n_mismatch++;
							if (n_mismatch <= 10)
								$display("matrix %0d entry m%0d%0d: expected %0d got %0d",
									n_checked, e / 3, e % 3, $signed(exp_m[e*16 +: 16]),
									$signed(m_axis_tdata[e*16 +: 16]));
						end
					end
				end
			end
			if (sink_gap > 0) sink_gap <= sink_gap - 1;
			if (hold_sink) m_axis_tready <= 1'b0;
			else if (calm) m_axis_tready <= 1'b1;
			else if (sink_gap == 0 && $urandom_range(0, 12) == 0) begin
				m_axis_tready <= 1'b0;
				sink_gap <= $urandom_range(1, 17);
			end else m_axis_tready <= (sink_gap <= 1);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d matrices outstanding", expected_matrices.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_angles(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		pending_angles.push_back({z, y, x});
	endtask

	initial begin
		// directed: zero, extremes, quarter and half turns, beyond pi, all bits
		queue_angles(16'd0, 16'd0, 16'd0);
		queue_angles(16'h7FFF, 16'h8000, 16'h7FFF);
		queue_angles(16'h8000, 16'h7FFF, 16'h8000);
		queue_angles(16'hFFFF, 16'h0001, 16'hFFFF);
		queue_angles(16'd12868, 16'd0, 16'd0);
		queue_angles(16'd0, 16'd12868, 16'd0);
		queue_angles(16'd0, -16'sd12868, 16'd0);
		queue_angles(16'd0, 16'd0, 16'd12868);
		queue_angles(16'd25736, 16'd25736, 16'd25736);
		queue_angles(-16'sd25736, -16'sd25736, -16'sd25736);
		queue_angles(16'd6434, 16'd6434, 16'd6434);
		queue_angles(16'd30000, -16'sd30000, 16'd27000);
		queue_angles(16'h5555, 16'hAAAA, 16'h5555);
		queue_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		queue_angles(16'd4289, 16'd8579, 16'd17157);
		queue_angles(16'd1, 16'd2, 16'd3);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) queue_angles(rand_angle(), rand_angle(), rand_angle());
		wait (pending_angles.size() == 0 && expected_matrices.size() == 0);
		// long receiver hold while the sender keeps offering, to fill the pipeline
		repeat (200) queue_angles(rand_angle(), rand_angle(), rand_angle());
		@(posedge clk);
		hold_sink <= 1'b1;
		repeat (120) @(posedge clk);
		hold_sink <= 1'b0;
		// sender pauses until everything has drained
		wait (pending_angles.size() == 0);
		pause_src <= 1'b1;
		wait (expected_matrices.size() == 0);
		@(posedge clk);
		pause_src <= 1'b0;
		repeat (N_RANDOM - 500) queue_angles(rand_angle(), rand_angle(), rand_angle());
		wait (pending_angles.size() < 100);
		calm <= 1'b1;
		wait (pending_angles.size() == 0 && !s_axis_tvalid);
		wait (expected_matrices.size() == 0);
		repeat (DRAIN) @(posedge clk);
		$display("sent %0d angle triples (corners, wrap-around, random), checked %0d matrices",
			n_sent, n_checked);
		$display("under random source and sink stalls, a long sink hold and a source drain pause");
		if (n_mismatch == 0 && expected_matrices.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", n_mismatch);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/e2r_pkg.sv
rtl/e2r_cell.sv
rtl/euler_to_rotation_matrix_top.sv
rtl/e2r_checker.sv
bench/tb_euler_to_rotation_matrix_top.sv
